### rtl/bsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared constants for the block substream framer: widths, header characters,
// end marker and configuration register indexes.
// ----------------------------------------------------------------------------
package bsf_pkg;

    // width of the block bit counter, one bit wider than the block length register
    localparam int COUNT_WIDTH = 27;

    localparam int BYTE_W      = 8;
    localparam int SHIFT_W     = 3;
    localparam int BLOCK_W     = 26;
    localparam int DIGIT_W     = 6;
    localparam int CRC_W       = 32;
    localparam int MARK_W      = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = BLOCK_W;

    // trailer is end marker plus crc, preceded by up to seven partial bits
    localparam int TRAIL_W     = MARK_W + CRC_W;
    localparam int TAIL_W      = TRAIL_W + BYTE_W;
    localparam int TAIL_CNT_W  = 4;
    localparam int TAIL_FULL   = TRAIL_W / BYTE_W;
    localparam int TAIL_PART   = TAIL_FULL + 1;

    localparam int HDR_LEN     = 4;
    localparam int HDR_CNT_W   = 3;
    localparam int PEND_W      = 5;

    // block bits [CRC_LO, CRC_HI) carry the block crc
    localparam int CRC_LO      = 48;
    localparam int CRC_HI      = 80;
    localparam int POS_W       = 7;

    localparam logic [MARK_W-1:0] END_MARK = 48'h177245385090;

    localparam logic [BYTE_W-1:0] HDR_CHARS [0:HDR_LEN-2] = '{8'h42, 8'h5A, 8'h68};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIGIT  = 2'd2;

    // register values after reset
    localparam logic [SHIFT_W-1:0] RST_START_SHIFT = 3'd0;
    localparam logic [BLOCK_W-1:0] RST_BLOCK_BITS  = 26'd80;
    localparam logic [DIGIT_W-1:0] RST_SIZE_DIGIT  = 6'd57;

endpackage
`default_nettype wire

### rtl/block_substream_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_substream_framer
// Rebuilds a standalone compressed stream from one block that starts at any
// bit of a source byte stream: header, realigned block bits, end marker, crc.
// ----------------------------------------------------------------------------
// order: an accepted source beat loads the pending burst registers; its first byte then passes to the output register
// throughput: one source beat per cycle while each beat gives at most one result and the output
//   is not stalled; the header beat (4 bytes, maybe a data byte) and finishing beat (maybe a
//   data byte, then 10 or 11 trailer bytes) drain one byte a cycle likewise and hold the source off
// reset: i_rst_n synchronous active low; clears counters, crc, flags, pending burst
//   and output valid, and loads the register defaults
module block_substream_framer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [bsf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bsf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // source stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,   // [7:0] source_byte
    input  wire logic                              i_s_tlast,   // source_end
    // rebuilt stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [7:0]                             o_m_tdata,   // [7:0] out_byte
    output logic                                   o_m_tlast,   // out_last
    output logic [0:0]                             o_m_tuser    // [0] out_error
);
    import bsf_pkg::*;

    // configuration registers
    logic [SHIFT_W-1:0]     r_start_shift;
    logic [BLOCK_W-1:0]     r_block_bits;
    logic [DIGIT_W-1:0]     r_size_digit;

    // framing state
    logic [BYTE_W-1:0]      r_held, n_held;
    logic [COUNT_WIDTH-1:0] r_bits_seen, n_bits_seen;
    logic [CRC_W-1:0]       r_crc, n_crc;
    logic                   r_hdr_sent;
    logic                   r_job_done, n_job_done;

    // pending burst: header bytes, one data byte, then tail bytes
    logic [HDR_CNT_W-1:0]   r_hdr_left, n_hdr_left;
    logic                   r_data_v, n_data_v;
    logic [BYTE_W-1:0]      r_data_byte, n_data_byte;
    logic [TAIL_W-1:0]      r_tail, n_tail;
    logic [TAIL_CNT_W-1:0]  r_tail_cnt, n_tail_cnt;
    logic                   r_fin_err, n_fin_err;

    // output register
    logic                   r_o_valid;
    logic [BYTE_W-1:0]      r_o_byte, n_o_byte;
    logic                   r_o_last;
    logic                   r_o_err;

    logic [PEND_W-1:0]      pend_cnt;
    logic                   pend_empty;
    logic                   pop;
    logic                   accept;

    // per-beat datapath
    logic [COUNT_WIDTH-1:0] total;
    logic [COUNT_WIDTH-1:0] remain;
    logic                   under_total;
    logic [SHIFT_W-1:0]     first_bit;
    logic [3:0]             avail;
    logic [3:0]             take_n;
    logic [BYTE_W-1:0]      src_al;
    logic [BYTE_W-1:0]      take_mask;
    logic [2*BYTE_W-1:0]    merged;
    logic [3:0]             fill;
    logic                   step_data_v;
    logic [BYTE_W-1:0]      step_data;
    logic [BYTE_W-1:0]      acc_new;
    logic [SHIFT_W-1:0]     cnt_new;
    logic [COUNT_WIDTH-1:0] bits_new;
    logic                   complete;
    logic [POS_W-1:0]       crc_base;
    logic [CRC_W-1:0]       crc_step;
    logic [TAIL_W-1:0]      trail_word;

    // ------------------------------------------------------------------
    // handshakes: the burst drains into the output register whenever that
    // register is free or being taken; a new source beat is taken once the
    // burst is empty or its final byte leaves this cycle
    // ------------------------------------------------------------------
    assign pend_cnt   = PEND_W'(r_hdr_left) + PEND_W'(r_data_v) + PEND_W'(r_tail_cnt);
    assign pend_empty = (pend_cnt == '0);
    assign pop        = !pend_empty && (!r_o_valid || i_m_tready);
    assign o_s_tready = pend_empty || (pop && pend_cnt == PEND_W'(1));
    assign accept     = i_s_tvalid && o_s_tready;

    assign o_m_tvalid   = r_o_valid;
    assign o_m_tdata    = r_o_byte;
    assign o_m_tlast    = r_o_last;
    assign o_m_tuser[0] = r_o_err;

    // ------------------------------------------------------------------
    // bit realignment for one source byte
    // ------------------------------------------------------------------
    always_comb begin
        total       = COUNT_WIDTH'(r_block_bits);
        under_total = (r_bits_seen < total);
        remain      = total - r_bits_seen;
        first_bit   = r_hdr_sent ? '0 : r_start_shift;
        avail       = 4'(BYTE_W) - {1'b0, first_bit};
        // bits taken from this byte: what is left of the byte or of the block
        if (!under_total) begin
            take_n = '0;
        end else if (remain < COUNT_WIDTH'(avail)) begin
            take_n = remain[3:0];
        end else begin
            take_n = avail;
        end

        src_al    = i_s_tdata << first_bit;
        take_mask = ~(8'hFF >> take_n);
        merged    = {r_held, 8'h00} | ({src_al & take_mask, 8'h00} >> r_bits_seen[2:0]);
        fill      = {1'b0, r_bits_seen[2:0]} + take_n;

        step_data_v = fill[3];
        step_data   = merged[15:8];
        acc_new     = fill[3] ? merged[7:0] : merged[15:8];
        cnt_new     = fill[2:0];

        bits_new = r_bits_seen + COUNT_WIDTH'(take_n);
        complete = (bits_new >= total);
    end

    // crc capture: shift in the taken bits that fall in the crc window
    always_comb begin
        logic [POS_W:0] pos;
        crc_base = (r_bits_seen < COUNT_WIDTH'(CRC_HI)) ? r_bits_seen[POS_W-1:0]
                                                        : {POS_W{1'b1}};
        crc_step = r_crc;
        for (int j = 0; j < BYTE_W; j++) begin
            pos = {1'b0, crc_base} + (POS_W+1)'(j);
            if (4'(j) < take_n && pos >= (POS_W+1)'(CRC_LO) && pos < (POS_W+1)'(CRC_HI)) begin
                crc_step = {crc_step[CRC_W-2:0], src_al[BYTE_W-1-j]};
            end
        end
    end

    // trailer placed right after the partial byte bits
    assign trail_word = {acc_new, {TRAIL_W{1'b0}}}
                      | ({END_MARK, crc_step, {BYTE_W{1'b0}}} >> cnt_new);

    // ------------------------------------------------------------------
    // next state on an accepted beat, and burst drain
    // ------------------------------------------------------------------
    always_comb begin
        n_held      = r_held;
        n_bits_seen = r_bits_seen;
        n_crc       = r_crc;
        n_job_done  = r_job_done;

        n_hdr_left  = r_hdr_left;
        n_data_v    = r_data_v;
        n_data_byte = r_data_byte;
        n_tail      = r_tail;
        n_tail_cnt  = r_tail_cnt;
        n_fin_err   = r_fin_err;
        n_o_byte    = r_o_byte;

        // take the next burst byte into the output register
        if (pop) begin
            if (r_hdr_left != '0) begin
                if (r_hdr_left == HDR_CNT_W'(1)) begin
                    n_o_byte = BYTE_W'(r_size_digit);
                end else begin
                    n_o_byte = HDR_CHARS[2'(HDR_LEN - int'(r_hdr_left))];
                end
                n_hdr_left = r_hdr_left - HDR_CNT_W'(1);
            end else if (r_data_v) begin
                n_o_byte = r_data_byte;
                n_data_v = 1'b0;
            end else begin
                n_o_byte   = r_tail[TAIL_W-1 -: BYTE_W];
                n_tail     = r_tail << BYTE_W;
                n_tail_cnt = r_tail_cnt - TAIL_CNT_W'(1);
            end
        end

        // load the burst of a new beat; a finished job gives nothing
        if (accept) begin
            n_hdr_left  = '0;
            n_data_v    = 1'b0;
            n_tail_cnt  = '0;
            n_fin_err   = 1'b0;
            if (!r_job_done) begin
                n_hdr_left  = r_hdr_sent ? '0 : HDR_CNT_W'(HDR_LEN);
                n_data_v    = step_data_v;
                n_data_byte = step_data;
                n_bits_seen = bits_new;
                n_crc       = crc_step;
                if (complete) begin
                    // end marker and crc, final byte zero padded
                    n_tail     = trail_word;
                    n_tail_cnt = (cnt_new == '0) ? TAIL_CNT_W'(TAIL_FULL)
                                                 : TAIL_CNT_W'(TAIL_PART);
                    n_job_done = 1'b1;
                    n_held     = '0;
                end else if (i_s_tlast) begin
                    // truncated source: flush partial byte, or a zero byte
                    // when the beat would give nothing at all
                    n_tail = {acc_new, {TRAIL_W{1'b0}}};
                    if (cnt_new != '0 || (r_hdr_sent && !step_data_v)) begin
                        n_tail_cnt = TAIL_CNT_W'(1);
                    end
                    n_fin_err  = 1'b1;
                    n_job_done = 1'b1;
                    n_held     = '0;
                end else begin
                    n_held = acc_new;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_shift <= RST_START_SHIFT;
            r_block_bits  <= RST_BLOCK_BITS;
            r_size_digit  <= RST_SIZE_DIGIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_SHIFT: r_start_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_BLOCK_BITS:  r_block_bits  <= i_cfg_data[BLOCK_W-1:0];
                CFG_SIZE_DIGIT:  r_size_digit  <= i_cfg_data[DIGIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_bits_seen <= '0;
            r_crc       <= '0;
            r_hdr_sent  <= 1'b0;
            r_job_done  <= 1'b0;
            r_hdr_left  <= '0;
            r_data_v    <= 1'b0;
            r_tail_cnt  <= '0;
            r_fin_err   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_o_last    <= 1'b0;
            r_o_err     <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_bits_seen <= n_bits_seen;
            r_crc       <= n_crc;
            r_job_done  <= n_job_done;
            if (accept) begin
                r_hdr_sent <= 1'b1;
            end
            r_hdr_left  <= n_hdr_left;
            r_data_v    <= n_data_v;
            r_tail_cnt  <= n_tail_cnt;
            r_fin_err   <= n_fin_err;
            // only the closing byte of the final burst is the stream end
            if (pop) begin
                r_o_valid <= 1'b1;
                r_o_last  <= (pend_cnt == PEND_W'(1)) && r_job_done;
                r_o_err   <= (pend_cnt == PEND_W'(1)) && r_fin_err;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data_byte <= n_data_byte;
        r_tail      <= n_tail;
        r_o_byte    <= n_o_byte;
    end

`ifndef SYNTH
    // an error beat is always the closing beat of the stream
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err |-> r_o_last)
        else $error("error flag on a beat that is not last");

    // one source beat never leaves more than sixteen bytes pending
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend_cnt <= PEND_W'(16))
        else $error("pending burst exceeds its bound");

    // source is held off only while a burst is draining
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> !pend_empty)
        else $error("source stalled with nothing pending");

    // once the job is over and drained, no further beat appears
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_done && pend_empty && !r_o_valid |=> !r_o_valid)
        else $error("output beat after the job ended");
`endif

endmodule
`default_nettype wire
